/* hdl/gaps_pkg.sv */
package gaps_pkg;

    localparam int GRID_W  = 64;
    localparam int GRID_H  = 64;
    localparam int CELLS   = GRID_W * GRID_H;
    localparam int COORD_W = 6;
    localparam int CELL_W  = 12;
    localparam int LEN_W   = 13;
    localparam int DIR_W   = 4;
    localparam int G_W     = 21;
    localparam int F_W     = 22;
    localparam int H_W     = 16;

    localparam logic [CELL_W-1:0] CELL_LAST = CELL_W'(CELLS - 1);
    localparam logic [LEN_W-1:0]  CELL_COUNT = LEN_W'(CELLS);
    localparam logic [G_W-1:0]    STEP_ORTH = G_W'(256);
    localparam logic [G_W-1:0]    STEP_DIAG = G_W'(362);
    localparam logic [G_W-1:0]    G_MAX = {G_W{1'b1}};
    localparam logic [F_W-1:0]    F_MAX = {F_W{1'b1}};
    localparam logic [DIR_W-1:0]  DIR_NONE = 4'd0;
    localparam logic [DIR_W-1:0]  DIR_FIRST = 4'd1;
    localparam logic [DIR_W-1:0]  DIR_FIRST_DIAG = 4'd5;
    localparam logic [DIR_W-1:0]  DIR_LAST = 4'd8;

    localparam logic [LEN_W-1:0]  MAX_EXP_RESET = 13'd4096;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_SEARCH = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_ACK     = 2'd0,
        ST_FOUND   = 2'd1,
        ST_NO_PATH = 2'd2,
        ST_LIMIT   = 2'd3
    } status_t;

    typedef enum logic {
        CFG_MAX_EXP = 1'b0,
        CFG_DIAG    = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic             open;
        logic             closed;
        logic [DIR_W-1:0] dir;
        logic [G_W-1:0]   g;
        logic [F_W-1:0]   f;
    } node_t;

    typedef struct packed {
        logic               valid;
        status_t            status;
        logic [LEN_W-1:0]   length;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] z;
    } result_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_SQUARE,
        SQ_ITER,
        SQ_DONE
    } sq_state_t;

    typedef enum logic [4:0] {
        E_FLAG_CLR,
        E_IDLE,
        E_READ,
        E_CLEAR,
        E_H_START,
        E_H_WAIT,
        E_LIMIT,
        E_SCAN,
        E_SCAN_END,
        E_PICK,
        E_NB_START,
        E_NB_A,
        E_NB_B,
        E_NB_C,
        E_NB_N,
        E_NB_H,
        E_NB_NEXT,
        E_PA_CHK,
        E_PB_WR
    } eng_state_t;

    function automatic logic [1:0] move_dx(input logic [DIR_W-1:0] d);
        logic [1:0] r;
        case (d)
            4'd1, 4'd5, 4'd6: r = 2'b01;
            4'd2, 4'd7, 4'd8: r = 2'b11;
            default:          r = 2'b00;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] move_dz(input logic [DIR_W-1:0] d);
        logic [1:0] r;
        case (d)
            4'd3, 4'd5, 4'd7: r = 2'b01;
            4'd4, 4'd6, 4'd8: r = 2'b11;
            default:          r = 2'b00;
        endcase
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

/* hdl/gaps_sqrt.sv */
module gaps_sqrt
    import gaps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [COORD_W-1:0] dx,
    input  logic [COORD_W-1:0] dz,
    output logic               done,
    output logic [H_W-1:0]     root
);

    sq_state_t        state_reg, state_next;
    logic [COORD_W-1:0] dx_reg, dx_next, dz_reg, dz_next;
    logic [28:0]      rem_reg, rem_next;
    logic [29:0]      res_reg, res_next;
    logic [28:0]      bit_reg, bit_next;
    logic [29:0]      trial;
    logic [12:0]      sq_sum;

    assign trial  = res_reg + {1'b0, bit_reg};
    assign sq_sum = 13'(dx_reg * dx_reg) + 13'(dz_reg * dz_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SQ_IDLE:   if (start) state_next = SQ_SQUARE;
            SQ_SQUARE: state_next = SQ_ITER;
            SQ_ITER:   if (bit_reg[0]) state_next = SQ_DONE;
            SQ_DONE:   state_next = SQ_IDLE;
            default:   state_next = SQ_IDLE;
        endcase
    end

    always_comb
    begin
        dx_next  = dx_reg;
        dz_next  = dz_reg;
        rem_next = rem_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        case (state_reg)
            SQ_IDLE:
            begin
                dx_next = dx;
                dz_next = dz;
            end
            SQ_SQUARE:
            begin
                rem_next = {sq_sum, 16'b0};
                res_next = '0;
                bit_next = 29'h1000_0000;
            end
            SQ_ITER:
            begin
                if ({1'b0, rem_reg} >= trial)
                begin
                    rem_next = rem_reg - trial[28:0];
                    res_next = (res_reg >> 1) + {1'b0, bit_reg};
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
            default:
            begin
                dx_next = dx_reg;
            end
        endcase
    end

    assign done = (state_reg == SQ_DONE);
    assign root = res_reg[H_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= dx_next;
        dz_reg  <= dz_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

endmodule

/* hdl/gaps_engine.sv */
module gaps_engine
    import gaps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  op_t                cmd_op,
    input  logic [COORD_W-1:0] cmd_x,
    input  logic [COORD_W-1:0] cmd_z,
    input  logic [COORD_W-1:0] cmd_tx,
    input  logic [COORD_W-1:0] cmd_tz,
    input  logic               cmd_blocked,
    input  logic               cmd_forbidden,
    input  logic [CELL_W-1:0]  cmd_index,
    input  logic [LEN_W-1:0]   max_exp,
    input  logic               diag_en,
    output logic               busy,
    output result_t            result
);

    logic [1:0]        flag_mem [CELLS];
    node_t             node_mem [CELLS];
    logic [CELL_W-1:0] path_mem [CELLS];

    logic              flag_we;
    logic [CELL_W-1:0] flag_waddr, flag_raddr;
    logic [1:0]        flag_wdata, flag_rd_reg;
    logic              node_we;
    logic [CELL_W-1:0] node_waddr, node_raddr;
    node_t             node_wdata, node_rd_reg;
    logic              path_we;
    logic [CELL_W-1:0] path_waddr, path_wdata, path_raddr, path_rd_reg;

    eng_state_t        state_reg, state_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic [LEN_W-1:0]  exp_reg, exp_next;
    logic [LEN_W-1:0]  stored_len_reg, stored_len_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              found_reg, found_next;
    logic              scan_vld_reg, scan_vld_next;
    logic [CELL_W-1:0] scan_addr_reg, scan_addr_next;
    logic [CELL_W-1:0] cur_reg, cur_next;
    logic [CELL_W-1:0] walk_reg, walk_next;
    logic [CELL_W-1:0] idx_reg, idx_next;
    logic [COORD_W-1:0] tx_reg, tx_next, tz_reg, tz_next;
    logic [F_W-1:0]    best_f_reg, best_f_next;
    logic [G_W-1:0]    best_g_reg, best_g_next;
    logic [DIR_W-1:0]  best_dir_reg, best_dir_next;
    logic [DIR_W-1:0]  dir_reg, dir_next;
    logic [G_W-1:0]    tent_reg, tent_next;

    logic              sq_start, sq_done;
    logic [COORD_W-1:0] sq_dx, sq_dz;
    logic [H_W-1:0]    sq_root;

    logic [COORD_W-1:0] cur_x, cur_z, walk_x, walk_z, nx, nz, par_x, par_z;
    logic [1:0]        ddx, ddz, wdx, wdz;
    logic [6:0]        nx7, nz7;
    logic              nb_out, nb_diag, nb_update, scan_better, walk_more;
    logic [F_W-1:0]    tent_sum;
    logic [G_W-1:0]    tent;
    logic [F_W:0]      f_sum;
    logic [F_W-1:0]    f_new;
    logic [CELL_W-1:0] nb_cell;

    gaps_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .dx    (sq_dx),
        .dz    (sq_dz),
        .done  (sq_done),
        .root  (sq_root)
    );

    assign cur_x   = cur_reg[COORD_W-1:0];
    assign cur_z   = cur_reg[CELL_W-1:COORD_W];
    assign walk_x  = walk_reg[COORD_W-1:0];
    assign walk_z  = walk_reg[CELL_W-1:COORD_W];
    assign ddx     = move_dx(dir_reg);
    assign ddz     = move_dz(dir_reg);
    assign nx7     = {1'b0, cur_x} + {{5{ddx[1]}}, ddx};
    assign nz7     = {1'b0, cur_z} + {{5{ddz[1]}}, ddz};
    assign nx      = nx7[COORD_W-1:0];
    assign nz      = nz7[COORD_W-1:0];
    assign nb_out  = nx7[6] | nz7[6];
    assign nb_diag = (dir_reg >= DIR_FIRST_DIAG);
    assign nb_cell = {nz, nx};

    assign wdx     = move_dx(node_rd_reg.dir);
    assign wdz     = move_dz(node_rd_reg.dir);
    assign par_x   = walk_x - {{4{wdx[1]}}, wdx};
    assign par_z   = walk_z - {{4{wdz[1]}}, wdz};
    assign walk_more = (node_rd_reg.dir != DIR_NONE) && (len_reg < CELL_COUNT);

    assign tent_sum  = {1'b0, best_g_reg} + {1'b0, (nb_diag ? STEP_DIAG : STEP_ORTH)};
    assign tent      = (tent_sum > {1'b0, G_MAX}) ? G_MAX : tent_sum[G_W-1:0];
    assign nb_update = !node_rd_reg.open || (tent < node_rd_reg.g);
    assign f_sum     = {2'b0, tent_reg} + {{(F_W+1-H_W){1'b0}}, sq_root};
    assign f_new     = (f_sum > {1'b0, F_MAX}) ? F_MAX : f_sum[F_W-1:0];

    assign scan_better = scan_vld_reg && node_rd_reg.open &&
                         (!found_reg || (node_rd_reg.f < best_f_reg));

    assign busy = (state_reg != E_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            E_FLAG_CLR: if (cnt_reg[CELL_W-1:0] == CELL_LAST) state_next = E_IDLE;
            E_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd_op == OP_SEARCH)
                        state_next = E_CLEAR;
                    else if (cmd_op == OP_READ)
                        state_next = E_READ;
                end
            end
            E_READ:     state_next = E_IDLE;
            E_CLEAR:    if (cnt_reg[CELL_W-1:0] == CELL_LAST) state_next = E_H_START;
            E_H_START:  state_next = E_H_WAIT;
            E_H_WAIT:   if (sq_done) state_next = E_LIMIT;
            E_LIMIT:    state_next = (exp_reg >= max_exp) ? E_IDLE : E_SCAN;
            E_SCAN:     if (cnt_reg[CELL_W-1:0] == CELL_LAST) state_next = E_SCAN_END;
            E_SCAN_END: state_next = E_PICK;
            E_PICK:
            begin
                if (!found_reg)
                    state_next = E_IDLE;
                else if (cur_reg == {tz_reg, tx_reg})
                    state_next = E_PA_CHK;
                else
                    state_next = E_NB_START;
            end
            E_NB_START:
            begin
                if (nb_diag && !diag_en)
                    state_next = E_LIMIT;
                else if (nb_out)
                    state_next = E_NB_NEXT;
                else if (nb_diag)
                    state_next = E_NB_A;
                else
                    state_next = E_NB_C;
            end
            E_NB_A:     state_next = flag_rd_reg[0] ? E_NB_NEXT : E_NB_B;
            E_NB_B:     state_next = flag_rd_reg[0] ? E_NB_NEXT : E_NB_C;
            E_NB_C:     state_next = (flag_rd_reg != 2'b00) ? E_NB_NEXT : E_NB_N;
            E_NB_N:
            begin
                if (!node_rd_reg.closed && nb_update)
                    state_next = E_NB_H;
                else
                    state_next = E_NB_NEXT;
            end
            E_NB_H:     if (sq_done) state_next = E_NB_NEXT;
            E_NB_NEXT:  state_next = (dir_reg == DIR_LAST) ? E_LIMIT : E_NB_START;
            E_PA_CHK:   if (!walk_more) state_next = E_PB_WR;
            E_PB_WR:    if (cnt_reg == '0) state_next = E_IDLE;
            default:    state_next = E_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next        = cnt_reg;
        exp_next        = exp_reg;
        stored_len_next = stored_len_reg;
        len_next        = len_reg;
        found_next      = found_reg;
        scan_vld_next   = scan_vld_reg;
        scan_addr_next  = scan_addr_reg;
        cur_next        = cur_reg;
        walk_next       = walk_reg;
        idx_next        = idx_reg;
        tx_next         = tx_reg;
        tz_next         = tz_reg;
        best_f_next     = best_f_reg;
        best_g_next     = best_g_reg;
        best_dir_next   = best_dir_reg;
        dir_next        = dir_reg;
        tent_next       = tent_reg;
        flag_we         = 1'b0;
        flag_waddr      = {cmd_z, cmd_x};
        flag_wdata      = {cmd_forbidden, cmd_blocked};
        flag_raddr      = nb_cell;
        node_we         = 1'b0;
        node_waddr      = cnt_reg[CELL_W-1:0];
        node_wdata      = '0;
        node_raddr      = cnt_reg[CELL_W-1:0];
        path_we         = 1'b0;
        path_waddr      = cnt_reg[CELL_W-1:0];
        path_wdata      = walk_reg;
        path_raddr      = cmd_index;
        sq_start        = 1'b0;
        sq_dx           = abs_diff(nx, tx_reg);
        sq_dz           = abs_diff(nz, tz_reg);
        result          = '{valid: 1'b0, status: ST_ACK, length: stored_len_reg,
                            x: '0, z: '0};
        case (state_reg)
            E_FLAG_CLR:
            begin
                flag_we    = 1'b1;
                flag_waddr = cnt_reg[CELL_W-1:0];
                flag_wdata = 2'b00;
                cnt_next   = (cnt_reg[CELL_W-1:0] == CELL_LAST) ? '0 : cnt_reg + 1'b1;
            end
            E_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd_op)
                        OP_WRITE:
                        begin
                            flag_we      = 1'b1;
                            result.valid = 1'b1;
                        end
                        OP_SEARCH:
                        begin
                            cur_next        = {cmd_z, cmd_x};
                            tx_next         = cmd_tx;
                            tz_next         = cmd_tz;
                            cnt_next        = '0;
                            exp_next        = '0;
                            stored_len_next = '0;
                        end
                        OP_READ:
                        begin
                            idx_next = cmd_index;
                        end
                        default:
                        begin
                            result.valid = 1'b1;
                        end
                    endcase
                end
            end
            E_READ:
            begin
                result.valid = 1'b1;
                if ({1'b0, idx_reg} < stored_len_reg)
                begin
                    result.x = path_rd_reg[COORD_W-1:0];
                    result.z = path_rd_reg[CELL_W-1:COORD_W];
                end
            end
            E_CLEAR:
            begin
                node_we  = 1'b1;
                cnt_next = (cnt_reg[CELL_W-1:0] == CELL_LAST) ? '0 : cnt_reg + 1'b1;
            end
            E_H_START:
            begin
                sq_start = 1'b1;
                sq_dx    = abs_diff(cur_x, tx_reg);
                sq_dz    = abs_diff(cur_z, tz_reg);
            end
            E_H_WAIT:
            begin
                if (sq_done)
                begin
                    node_we    = 1'b1;
                    node_waddr = cur_reg;
                    node_wdata = '{open: 1'b1, closed: 1'b0, dir: DIR_NONE, g: '0,
                                   f: {{(F_W-H_W){1'b0}}, sq_root}};
                end
            end
            E_LIMIT:
            begin
                cnt_next      = '0;
                found_next    = 1'b0;
                scan_vld_next = 1'b0;
                if (exp_reg >= max_exp)
                begin
                    result.valid  = 1'b1;
                    result.status = ST_LIMIT;
                end
            end
            E_SCAN, E_SCAN_END:
            begin
                if (scan_better)
                begin
                    found_next    = 1'b1;
                    cur_next      = scan_addr_reg;
                    best_f_next   = node_rd_reg.f;
                    best_g_next   = node_rd_reg.g;
                    best_dir_next = node_rd_reg.dir;
                end
                scan_vld_next  = 1'b1;
                scan_addr_next = cnt_reg[CELL_W-1:0];
                cnt_next       = cnt_reg + 1'b1;
            end
            E_PICK:
            begin
                if (!found_reg)
                begin
                    result.valid  = 1'b1;
                    result.status = ST_NO_PATH;
                end
                else if (cur_reg == {tz_reg, tx_reg})
                begin
                    walk_next  = cur_reg;
                    len_next   = LEN_W'(1);
                    node_raddr = cur_reg;
                end
                else
                begin
                    node_we    = 1'b1;
                    node_waddr = cur_reg;
                    node_wdata = '{open: 1'b0, closed: 1'b1, dir: best_dir_reg,
                                   g: best_g_reg, f: best_f_reg};
                    dir_next   = DIR_FIRST;
                end
            end
            E_NB_START:
            begin
                if (nb_diag && !diag_en)
                    exp_next = exp_reg + 1'b1;
                flag_raddr = nb_diag ? {cur_z, nx} : nb_cell;
            end
            E_NB_A:
            begin
                flag_raddr = {nz, cur_x};
            end
            E_NB_B, E_NB_C:
            begin
                node_raddr = nb_cell;
            end
            E_NB_N:
            begin
                tent_next = tent;
                if (!node_rd_reg.closed && nb_update)
                    sq_start = 1'b1;
            end
            E_NB_H:
            begin
                if (sq_done)
                begin
                    node_we    = 1'b1;
                    node_waddr = nb_cell;
                    node_wdata = '{open: 1'b1, closed: 1'b0, dir: dir_reg,
                                   g: tent_reg, f: f_new};
                end
            end
            E_NB_NEXT:
            begin
                if (dir_reg == DIR_LAST)
                    exp_next = exp_reg + 1'b1;
                else
                    dir_next = dir_reg + 1'b1;
            end
            E_PA_CHK:
            begin
                if (walk_more)
                begin
                    walk_next  = {par_z, par_x};
                    len_next   = len_reg + 1'b1;
                    node_raddr = {par_z, par_x};
                end
                else
                begin
                    stored_len_next = len_reg;
                    cnt_next        = len_reg - 1'b1;
                    walk_next       = cur_reg;
                    node_raddr      = cur_reg;
                end
            end
            E_PB_WR:
            begin
                path_we    = 1'b1;
                path_waddr = cnt_reg[CELL_W-1:0];
                path_wdata = walk_reg;
                if (node_rd_reg.dir != DIR_NONE)
                    walk_next = {par_z, par_x};
                node_raddr = walk_next;
                if (cnt_reg == '0)
                begin
                    result.valid  = 1'b1;
                    result.status = ST_FOUND;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= E_FLAG_CLR;
            cnt_reg        <= '0;
            exp_reg        <= '0;
            stored_len_reg <= '0;
            found_reg      <= 1'b0;
            scan_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            exp_reg        <= exp_next;
            stored_len_reg <= stored_len_next;
            found_reg      <= found_next;
            scan_vld_reg   <= scan_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg       <= len_next;
        scan_addr_reg <= scan_addr_next;
        cur_reg       <= cur_next;
        walk_reg      <= walk_next;
        idx_reg       <= idx_next;
        tx_reg        <= tx_next;
        tz_reg        <= tz_next;
        best_f_reg    <= best_f_next;
        best_g_reg    <= best_g_next;
        best_dir_reg  <= best_dir_next;
        dir_reg       <= dir_next;
        tent_reg      <= tent_next;
    end

    always_ff @(posedge clk)
    begin
        if (flag_we)
            flag_mem[flag_waddr] <= flag_wdata;
        flag_rd_reg <= flag_mem[flag_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
            node_mem[node_waddr] <= node_wdata;
        node_rd_reg <= node_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (path_we)
            path_mem[path_waddr] <= path_wdata;
        path_rd_reg <= path_mem[path_raddr];
    end

endmodule

/* hdl/grid_astar_path_search_top.sv */
// A* path search over a 64 by 64 grid of cells, each with a blocked and a forbidden flag.
// An item is accepted on a rising edge with start high and busy low. Operation 0 writes
// the flags of one cell, operation 1 runs a search from pos to target, operation 2 reads
// one entry of the stored path, start first. Every item gives exactly one result, shown
// for one cycle with done high; the receiver cannot hold it off.
// A write or unused operation answers in the cycle after acceptance; a path read passes
// through the E_READ state and path memory read register before the done register.
// A search first clears all 4096 node entries, then each expansion scans all 4096 node
// entries through the single read port of the node memory and visits up to eight
// neighbors with flag and node reads plus the bit-serial square root for the heuristic.
// Path write-back walks the parent chain to count the path cells, then again to write them.
// After reset the block clears the cell flag memory with busy high; configuration writes
// through cfg_write, cfg_index and cfg_data are taken at any time.
module grid_astar_path_search_top
    import gaps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         operation,
    input  logic [COORD_W-1:0] pos_x,
    input  logic [COORD_W-1:0] pos_z,
    input  logic [COORD_W-1:0] target_x,
    input  logic [COORD_W-1:0] target_z,
    input  logic               blocked,
    input  logic               forbidden,
    input  logic [CELL_W-1:0]  path_index,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [LEN_W-1:0]   cfg_data,
    output logic               done,
    output logic [1:0]         status,
    output logic [LEN_W-1:0]   path_length,
    output logic [COORD_W-1:0] step_x,
    output logic [COORD_W-1:0] step_z
);

    logic [LEN_W-1:0]   max_exp_reg, max_exp_next;
    logic               diag_reg, diag_next;
    logic               done_reg;
    logic [1:0]         status_reg;
    logic [LEN_W-1:0]   length_reg;
    logic [COORD_W-1:0] x_reg, z_reg;
    logic               accept;
    result_t            eng_result;

    assign accept = start && !busy;

    gaps_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (accept),
        .cmd_op        (op_t'(operation)),
        .cmd_x         (pos_x),
        .cmd_z         (pos_z),
        .cmd_tx        (target_x),
        .cmd_tz        (target_z),
        .cmd_blocked   (blocked),
        .cmd_forbidden (forbidden),
        .cmd_index     (path_index),
        .max_exp       (max_exp_reg),
        .diag_en       (diag_reg),
        .busy          (busy),
        .result        (eng_result)
    );

    always_comb
    begin
        max_exp_next = max_exp_reg;
        diag_next    = diag_reg;
        if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MAX_EXP: max_exp_next = cfg_data;
                CFG_DIAG:    diag_next    = cfg_data[0];
                default:     diag_next    = diag_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_exp_reg <= MAX_EXP_RESET;
            diag_reg    <= 1'b1;
            done_reg    <= 1'b0;
        end
        else
        begin
            max_exp_reg <= max_exp_next;
            diag_reg    <= diag_next;
            done_reg    <= eng_result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= eng_result.status;
        length_reg <= eng_result.length;
        x_reg      <= eng_result.x;
        z_reg      <= eng_result.z;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign path_length = length_reg;
    assign step_x      = x_reg;
    assign step_z      = z_reg;

endmodule

/* tb/gaps_checker.sv */
module gaps_checker
    import gaps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         operation,
    input  logic [COORD_W-1:0] pos_x,
    input  logic [COORD_W-1:0] pos_z,
    input  logic [COORD_W-1:0] target_x,
    input  logic [COORD_W-1:0] target_z,
    input  logic               blocked,
    input  logic               forbidden,
    input  logic [CELL_W-1:0]  path_index,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [LEN_W-1:0]   cfg_data,
    input  logic               done,
    input  logic [1:0]         status,
    input  logic [LEN_W-1:0]   path_length,
    input  logic [COORD_W-1:0] step_x,
    input  logic [COORD_W-1:0] step_z,
    output int                 errors,
    output int                 pending,
    output int                 checked,
    output int                 found
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t            st;
        logic [LEN_W-1:0]   len;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] z;
    } answer_t;

    answer_t     answers_due[$];
    bit          cell_blk[CELLS];
    bit          cell_forb[CELLS];
    bit          in_open[CELLS];
    bit          in_closed[CELLS];
    int unsigned parent_dir[CELLS];
    int unsigned g_cost[CELLS];
    int unsigned f_cost[CELLS];
    int unsigned route[CELLS];
    int unsigned route_len;
    int unsigned max_exp;
    bit          diag_on;
    int          step_dx[9] = '{0, 1, -1, 0, 0, 1, 1, -1, -1};
    int          step_dz[9] = '{0, 0, 0, 1, -1, 1, -1, 1, -1};

    function automatic int unsigned dist_q8(int dx, int dz);
        longint unsigned v;
        longint unsigned res;
        longint unsigned b;
        v = longint'(dx * dx + dz * dz) << 16;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return int'(res);
    endfunction

    function automatic int unsigned sat(int unsigned a, int unsigned b, int unsigned lim);
        return (a + b > lim) ? lim : a + b;
    endfunction

    function automatic bit free_cell(int x, int z);
        if (x < 0 || z < 0 || x >= GRID_W || z >= GRID_H)
            return 0;
        return !cell_blk[z * GRID_W + x];
    endfunction

    function automatic int back_step(int c);
        int k;
        k = parent_dir[c];
        return (c / GRID_W - step_dz[k]) * GRID_W + (c % GRID_W - step_dx[k]);
    endfunction

    function automatic status_t find_route(int sx, int sz, int tx, int tz);
        int unsigned count;
        int unsigned best;
        int unsigned tent;
        int          cur;
        int          goal;
        int          cx;
        int          cz;
        int          nx;
        int          nz;
        int          ni;
        int          n;
        int          c;
        count = 0;
        goal = tz * GRID_W + tx;
        route_len = 0;
        for (int i = 0; i < CELLS; i++)
        begin
            in_open[i] = 0;
            in_closed[i] = 0;
            parent_dir[i] = 0;
        end
        cur = sz * GRID_W + sx;
        in_open[cur] = 1;
        g_cost[cur] = 0;
        f_cost[cur] = sat(0, dist_q8(sx - tx, sz - tz), F_MAX);
        forever
        begin
            if (count >= max_exp)
                return ST_LIMIT;
            cur = -1;
            best = 0;
            for (int i = 0; i < CELLS; i++)
                if (in_open[i] && (cur < 0 || f_cost[i] < best))
                begin
                    best = f_cost[i];
                    cur = i;
                end
            if (cur < 0)
                return ST_NO_PATH;
            if (cur == goal)
            begin
                n = 1;
                c = cur;
                while (parent_dir[c] != 0 && n < CELLS)
                begin
                    c = back_step(c);
                    n++;
                end
                route_len = n;
                c = cur;
                for (int i = n - 1; i >= 0; i--)
                begin
                    route[i] = c;
                    if (parent_dir[c] != 0)
                        c = back_step(c);
                end
                return ST_FOUND;
            end
            in_open[cur] = 0;
            in_closed[cur] = 1;
            cx = cur % GRID_W;
            cz = cur / GRID_W;
            for (int d = 1; d <= 8; d++)
            begin
                nx = cx + step_dx[d];
                nz = cz + step_dz[d];
                if (d >= 5)
                begin
                    if (!diag_on)
                        break;
                    if (!free_cell(nx, cz) || !free_cell(cx, nz))
                        continue;
                end
                if (!free_cell(nx, nz))
                    continue;
                ni = nz * GRID_W + nx;
                if (cell_forb[ni] || in_closed[ni])
                    continue;
                tent = sat(g_cost[cur], d >= 5 ? STEP_DIAG : STEP_ORTH, G_MAX);
                if (!in_open[ni] || tent < g_cost[ni])
                begin
                    parent_dir[ni] = d;
                    g_cost[ni] = tent;
                    f_cost[ni] = sat(tent, dist_q8(nx - tx, nz - tz), F_MAX);
                    in_open[ni] = 1;
                end
            end
            count++;
        end
    endfunction

    initial
    begin
        errors = 0;
        pending = 0;
        checked = 0;
        found = 0;
        max_exp = MAX_EXP_RESET;
        diag_on = 1;
        route_len = 0;
        for (int i = 0; i < CELLS; i++)
        begin
            cell_blk[i] = 0;
            cell_forb[i] = 0;
        end
    end

    always @(posedge clk)
    begin : watch
        answer_t want;
        answer_t got;
        int      c;
        if (rst_n)
        begin
            if (done)
            begin
                got.st = status_t'(status);
                got.len = path_length;
                got.x = step_x;
                got.z = step_z;
                if (answers_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result with none expected: %p", $realtime, got);
                end
                else
                begin
                    want = answers_due.pop_front();
                    checked++;
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch, expected %p, got %p",
                                     $realtime, want, got);
                    end
                end
            end
            if (cfg_write)
            begin
                if (cfg_idx_t'(cfg_index) == CFG_MAX_EXP)
                    max_exp = cfg_data;
                else
                    diag_on = cfg_data[0];
            end
            if (start && !busy)
            begin
                want = '0;
                want.st = ST_ACK;
                case (op_t'(operation))
                    OP_WRITE:
                    begin
                        c = pos_z * GRID_W + pos_x;
                        cell_blk[c] = blocked;
                        cell_forb[c] = forbidden;
                    end
                    OP_SEARCH:
                    begin
                        want.st = find_route(pos_x, pos_z, target_x, target_z);
                        if (want.st == ST_FOUND)
                            found++;
                    end
                    OP_READ:
                    begin
                        if (path_index < route_len)
                        begin
                            want.x = COORD_W'(route[path_index] % GRID_W);
                            want.z = COORD_W'(route[path_index] / GRID_W);
                        end
                    end
                    default: ;
                endcase
                want.len = LEN_W'(route_len);
                answers_due.insert(answers_due.size(), want);
            end
            pending <= answers_due.size();
        end
    end

endmodule

/* tb/tb.sv */
module tb;
    import gaps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               start = 0;
    logic               busy;
    logic [1:0]         operation = OP_WRITE;
    logic [COORD_W-1:0] pos_x = '0;
    logic [COORD_W-1:0] pos_z = '0;
    logic [COORD_W-1:0] target_x = '0;
    logic [COORD_W-1:0] target_z = '0;
    logic               blocked = 0;
    logic               forbidden = 0;
    logic [CELL_W-1:0]  path_index = '0;
    logic               cfg_write = 0;
    logic               cfg_index = CFG_MAX_EXP;
    logic [LEN_W-1:0]   cfg_data = '0;
    logic               done;
    logic [1:0]         status;
    logic [LEN_W-1:0]   path_length;
    logic [COORD_W-1:0] step_x;
    logic [COORD_W-1:0] step_z;
    int                 errors;
    int                 pending;
    int                 checked;
    int                 found;
    int                 sent = 0;

    always #5 clk = ~clk;

    grid_astar_path_search_top u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .operation(operation),
        .pos_x(pos_x), .pos_z(pos_z), .target_x(target_x), .target_z(target_z),
        .blocked(blocked), .forbidden(forbidden), .path_index(path_index),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .status(status), .path_length(path_length),
        .step_x(step_x), .step_z(step_z)
    );

    gaps_checker u_check (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .operation(operation),
        .pos_x(pos_x), .pos_z(pos_z), .target_x(target_x), .target_z(target_z),
        .blocked(blocked), .forbidden(forbidden), .path_index(path_index),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .status(status), .path_length(path_length),
        .step_x(step_x), .step_z(step_z),
        .errors(errors), .pending(pending), .checked(checked), .found(found)
    );

    task automatic issue(op_t op, int px, int pz, int tx, int tz, bit blk, bit forb,
                         int idx);
        int gap;
        int roll;
        operation <= op;
        pos_x <= COORD_W'(px);
        pos_z <= COORD_W'(pz);
        target_x <= COORD_W'(tx);
        target_z <= COORD_W'(tz);
        blocked <= blk;
        forbidden <= forb;
        path_index <= CELL_W'(idx);
        start <= 1;
        do
            @(posedge clk);
        while (busy);
        sent++;
        roll = $urandom_range(99);
        gap = (roll < 65) ? 0 : (roll < 93) ? $urandom_range(3, 1) : $urandom_range(40, 10);
        if (gap > 0)
        begin
            start <= 0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_reg(cfg_idx_t idx, int value);
        drain();
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= LEN_W'(value);
        @(posedge clk);
        cfg_write <= 0;
        @(posedge clk);
    endtask

    task automatic search(int px, int pz, int tx, int tz);
        issue(OP_SEARCH, px, pz, tx, tz, 0, 0, 0);
    endtask

    task automatic write_cell(int px, int pz, bit blk, bit forb);
        issue(OP_WRITE, px, pz, $urandom_range(63), $urandom_range(63), blk, forb, 0);
    endtask

    task automatic read_step(int idx);
        issue(OP_READ, 0, 0, 0, 0, 0, 0, idx);
    endtask

    task automatic random_item();
        int roll;
        int cx;
        int cz;
        roll = $urandom_range(99);
        cx = $urandom_range(36, 28);
        cz = $urandom_range(36, 28);
        if (roll < 35)
        begin
            if ($urandom_range(4) == 0)
                write_cell($urandom_range(63), $urandom_range(63), 1'($urandom_range(1)),
                           1'($urandom_range(1)));
            else
                write_cell(cx, cz, $urandom_range(3) == 0, $urandom_range(5) == 0);
        end
        else if (roll < 60)
        begin
            if ($urandom_range(4) == 0)
                search($urandom_range(63), $urandom_range(63), $urandom_range(63),
                       $urandom_range(63));
            else
                search(cx, cz, cx + $urandom_range(3) - 1, cz + $urandom_range(3) - 1);
        end
        else if (roll < 95)
            read_step($urandom_range(9) == 0 ? $urandom_range(4095) : $urandom_range(6));
        else
            issue(OP_NONE, $urandom_range(63), $urandom_range(63), $urandom_range(63),
                  $urandom_range(63), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  $urandom_range(4095));
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        write_cell(63, 63, 1, 1);
        write_cell(0, 0, 0, 0);
        search(5, 5, 5, 5);
        read_step(0);
        search(10, 10, 12, 12);
        read_step(0);
        read_step(2);
        read_step(3);
        read_step(4095);
        issue(OP_NONE, 63, 63, 63, 63, 1, 1, 4095);
        write_cell(11, 11, 1, 0);
        search(10, 10, 12, 12);
        read_step(1);
        write_cell(20, 20, 0, 1);
        search(19, 20, 21, 20);
        read_step(1);
        search(63, 63, 62, 62);
        write_cell(1, 0, 1, 0);
        write_cell(0, 1, 1, 0);
        search(0, 0, 5, 5);
        set_reg(CFG_DIAG, 0);
        search(10, 10, 12, 12);
        read_step(2);
        set_reg(CFG_MAX_EXP, 0);
        search(3, 3, 3, 3);
        set_reg(CFG_MAX_EXP, 8191);
        search(30, 30, 31, 31);
        set_reg(CFG_MAX_EXP, 3);
        set_reg(CFG_DIAG, 1);
        write_cell(40, 40, 1, 0);
        search(39, 39, 40, 40);
        set_reg(CFG_MAX_EXP, 4096);

        for (int phase = 0; phase < 4; phase++)
        begin
            set_reg(CFG_MAX_EXP, phase == 0 ? 1 : $urandom_range(8, 2));
            set_reg(CFG_DIAG, phase % 2);
            for (int i = 0; i < 20; i++)
                random_item();
        end

        drain();
        repeat (20) @(posedge clk);
        $display("Sent %0d items (writes, searches, path reads, unused op); checked %0d results.",
                 sent, checked);
        $display("Searches that found a path: %0d, over several limit and diagonal settings.",
                 found);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin
        #400ms;
        $display("tb failed");
        $finish;
    end

endmodule
